@@ hw/rtl/cfws_pkg.sv @@
// Shared types and constants for the byte FIFO with search commands.
`timescale 1ns / 1ps
`default_nettype none

package cfws_pkg;

    // Default queue depth in bytes.
    localparam int unsigned CFWS_CAPACITY = 128;

    typedef enum logic [2:0] {
        CMD_PUSH    = 3'd0,
        CMD_POP     = 3'd1,
        CMD_REPLACE = 3'd2,
        CMD_MEMBER  = 3'd3,
        CMD_COUNT   = 3'd4,
        CMD_MAX     = 3'd5,
        CMD_UPPER   = 3'd6,
        CMD_CLEAR   = 3'd7
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [7:0] ASCII_LOWER_A     = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z     = 8'h7A;
    localparam logic [7:0] ASCII_CASE_OFFSET = 8'd32;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] level;
        logic       is_empty_flag;
        logic       is_full_flag;
        logic [7:0] head_value;
        logic       found;
        logic [7:0] match_count;
        logic [7:0] max_value;
    } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/char_fifo_with_search.sv @@
// Top level of the byte FIFO with push, pop, search, count, max and uppercase commands.
// Single-entry commands (push, pop, replace tail, clear) and searches on an empty queue pass
// from IDLE through HEAD and DONE to the result register; member test, count, max and uppercase
// on a non-empty queue first walk every entry over the single read port of the entry memory.
// The block takes one command word at a time and stalls new words until the result is loaded.
// Reset: rst_n clears the pointers, the count and the sequencer; memory contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module char_fifo_with_search #(
    parameter int unsigned CAPACITY = cfws_pkg::CFWS_CAPACITY
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire cfws_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output cfws_pkg::rsp_t     rsp
);
    import cfws_pkg::*;

    localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

    // The sequencer: IDLE takes a command word and applies the single-entry commands at once.
    // WALK streams every held entry through the one read port, one slot a cycle; the word
    // read is registered and then goes through the shared compare unit. HEAD reads the
    // oldest entry, and DONE loads the result register once it is free.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_HEAD = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   rp_reg, rp_next;
    logic [ADDR_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    cmd_t                cmd_reg, cmd_next;
    logic [7:0]          data_reg, data_next;
    logic [1:0]          status_reg, status_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic [ADDR_W-1:0]   slot_reg, slot_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_slot_reg, pend_slot_next;
    logic                found_reg, found_next;
    logic [CNT_W-1:0]    match_reg, match_next;
    logic [7:0]          max_reg, max_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    // Entry memory: one write and one registered read per cycle.
    logic [7:0]          mem [CAPACITY];
    logic [7:0]          rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    logic [CNT_W+7:0]    cnt_ext;
    logic [CNT_W+7:0]    match_ext;
    logic                is_full;
    logic                queue_empty;
    logic [ADDR_W-1:0]   wp_inc;
    logic [ADDR_W-1:0]   rp_inc;
    logic [ADDR_W-1:0]   slot_inc;
    logic [ADDR_W-1:0]   tail_slot;

    assign cnt_ext     = {8'd0, cnt_reg};
    assign match_ext   = {8'd0, match_reg};
    assign is_full     = (cnt_reg == CNT_W'(CAPACITY));
    assign queue_empty = (cnt_reg == '0);

    // Pointers wrap explicitly so that any depth, not only a power of two, works.
    assign wp_inc    = (wp_reg == ADDR_W'(CAPACITY - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc    = (rp_reg == ADDR_W'(CAPACITY - 1)) ? '0 : rp_reg + 1'b1;
    assign slot_inc  = (slot_reg == ADDR_W'(CAPACITY - 1)) ? '0 : slot_reg + 1'b1;
    assign tail_slot = (wp_reg == '0) ? ADDR_W'(CAPACITY - 1) : wp_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        issue_next     = issue_reg;
        slot_next      = slot_reg;
        pend_next      = 1'b0;
        pend_slot_next = pend_slot_reg;
        found_next     = found_reg;
        match_next     = match_reg;
        max_next       = max_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = data_reg;
        mem_re         = 1'b0;
        mem_raddr      = slot_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next    = req.cmd;
                    data_next   = req.data;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    match_next  = '0;
                    max_next    = '0;
                    issue_next  = '0;
                    slot_next   = rp_reg;
                    state_next  = S_HEAD;
                    case (req.cmd)
                        CMD_PUSH:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = wp_reg;
                                mem_wdata = req.data;
                                wp_next   = wp_inc;
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            if (queue_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rp_next  = rp_inc;
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        CMD_REPLACE:
                        begin
                            if (queue_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = tail_slot;
                                mem_wdata = req.data;
                            end
                        end
                        CMD_MEMBER, CMD_COUNT, CMD_MAX, CMD_UPPER:
                        begin
                            // Count and max need data; member test and uppercase on an
                            // empty queue simply report success.
                            if (queue_empty)
                            begin
                                if (req.cmd == CMD_COUNT || req.cmd == CMD_MAX)
                                begin
                                    status_next = ST_EMPTY;
                                end
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            rp_next  = '0;
                            wp_next  = '0;
                            cnt_next = '0;
                        end
                        default:
                        begin
                            state_next = S_HEAD;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (issue_reg != cnt_reg)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = slot_reg;
                    slot_next      = slot_inc;
                    issue_next     = issue_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_slot_next = slot_reg;
                end
                else if (!pend_reg)
                begin
                    state_next = S_HEAD;
                end

                // Shared compare unit on the word read in the previous cycle.
                if (pend_reg)
                begin
                    case (cmd_reg)
                        CMD_MEMBER:
                        begin
                            if (rd_data_reg == data_reg)
                            begin
                                found_next = 1'b1;
                            end
                        end
                        CMD_COUNT:
                        begin
                            if (rd_data_reg == data_reg)
                            begin
                                match_next = match_reg + 1'b1;
                            end
                        end
                        CMD_MAX:
                        begin
                            if (rd_data_reg > max_reg)
                            begin
                                max_next = rd_data_reg;
                            end
                        end
                        CMD_UPPER:
                        begin
                            if (rd_data_reg >= ASCII_LOWER_A && rd_data_reg <= ASCII_LOWER_Z)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pend_slot_reg;
                                mem_wdata = rd_data_reg - ASCII_CASE_OFFSET;
                            end
                        end
                        default:
                        begin
                            found_next = found_reg;
                        end
                    endcase
                end
            end

            S_HEAD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = rp_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.level         = cnt_ext[7:0];
                    rsp_next.is_empty_flag = queue_empty;
                    rsp_next.is_full_flag  = is_full;
                    rsp_next.head_value    = queue_empty ? 8'd0 : rd_data_reg;
                    rsp_next.found         = found_reg;
                    rsp_next.match_count   = match_ext[7:0];
                    rsp_next.max_value     = max_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and working registers carry no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        data_reg      <= data_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        pend_slot_reg <= pend_slot_next;
        found_reg     <= found_next;
        match_reg     <= match_next;
        max_reg       <= max_next;
        rsp_reg       <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The entry count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // An accepted command word always makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("block took a second word before finishing the first");

    // The walk never issues more reads than there are entries.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (issue_reg <= cnt_reg))
        else $error("walk ran past the held entries");

    // An empty result reports no head byte and no member hit.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.is_empty_flag) |-> (rsp.head_value == 8'd0 && rsp.found == 1'b0))
        else $error("empty result carries data");

endmodule

`default_nettype wire

@@ bench/tb_char_fifo_with_search.sv @@
// Self-checking testbench for the byte FIFO with push, pop, search, count, max and uppercase.
`timescale 1ns / 1ps

module tb_char_fifo_with_search;

    import cfws_pkg::*;

    localparam int CAP         = CFWS_CAPACITY;
    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 7;
    localparam int WORDS_PER_PHASE = 495;
    // A walk over a full queue reads every entry; with sender gaps and
    // receiver stalls on top, this leaves several times the slowest correct run.
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int TAIL_CYCLES = CAP + 16;

    // Canned result words that can be read straight off the command.
    localparam rsp_t RSP_EMPTY_ERR = '{status: ST_EMPTY, level: 8'd0, is_empty_flag: 1'b1,
                                       is_full_flag: 1'b0, head_value: 8'd0, found: 1'b0,
                                       match_count: 8'd0, max_value: 8'd0};
    localparam rsp_t RSP_IDLE_OK   = '{status: ST_OK, level: 8'd0, is_empty_flag: 1'b1,
                                       is_full_flag: 1'b0, head_value: 8'd0, found: 1'b0,
                                       match_count: 8'd0, max_value: 8'd0};
    localparam rsp_t RSP_ONE_ZERO  = '{status: ST_OK, level: 8'd1, is_empty_flag: 1'b0,
                                       is_full_flag: 1'b0, head_value: 8'd0, found: 1'b0,
                                       match_count: 8'd0, max_value: 8'd0};

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       typed;
        rsp_t       want;
    } row_t;

    // Directed commands. Rows with typed set carry their own expected word; the
    // rest are checked against the queue model below.
    localparam int DIRECTED_ROWS = 24;
    localparam row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        // Every command on an empty queue right after reset.
        '{CMD_POP,     8'h00, 1'b1, RSP_EMPTY_ERR},
        '{CMD_REPLACE, 8'h5A, 1'b1, RSP_EMPTY_ERR},
        '{CMD_COUNT,   8'h00, 1'b1, RSP_EMPTY_ERR},
        '{CMD_MAX,     8'h00, 1'b1, RSP_EMPTY_ERR},
        '{CMD_MEMBER,  8'h00, 1'b1, RSP_IDLE_OK},
        '{CMD_UPPER,   8'h00, 1'b1, RSP_IDLE_OK},
        '{CMD_CLEAR,   8'h00, 1'b1, RSP_IDLE_OK},
        '{CMD_PUSH,    8'h00, 1'b1, RSP_ONE_ZERO},
        // Letters at and just outside the lowercase range, and a high-bit byte.
        '{CMD_PUSH,    8'h61, 1'b0, '0},
        '{CMD_PUSH,    8'h7A, 1'b0, '0},
        '{CMD_PUSH,    8'h60, 1'b0, '0},
        '{CMD_PUSH,    8'h7B, 1'b0, '0},
        '{CMD_PUSH,    8'hE1, 1'b0, '0},
        // The largest byte goes in last, so the max search must reach the tail.
        '{CMD_PUSH,    8'hFF, 1'b0, '0},
        '{CMD_MEMBER,  8'hFF, 1'b0, '0},
        '{CMD_MEMBER,  8'h55, 1'b0, '0},
        '{CMD_COUNT,   8'h61, 1'b0, '0},
        '{CMD_MAX,     8'h00, 1'b0, '0},
        '{CMD_UPPER,   8'h00, 1'b0, '0},
        '{CMD_MEMBER,  8'h41, 1'b0, '0},
        '{CMD_REPLACE, 8'h80, 1'b0, '0},
        '{CMD_MAX,     8'h00, 1'b0, '0},
        '{CMD_POP,     8'h00, 1'b0, '0},
        '{CMD_CLEAR,   8'h00, 1'b1, RSP_IDLE_OK}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Queue model: contents, oldest slot, next free slot and fill level.
    logic [7:0] byte_store [CAP];
    int head_slot;
    int tail_slot;
    int held_count;

    rsp_t awaited_words [$];
    int fail_count;
    int cycle_count;
    int tx_idle_pct;
    int rx_idle_pct;

    char_fifo_with_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Applies one command to the queue model and returns the word it should produce.
    function automatic rsp_t command_outcome(input req_t r);
        rsp_t       o;
        int         k;
        int         hits;
        logic [7:0] b;
        o = '0;
        hits = 0;
        case (r.cmd)
            CMD_PUSH:
            begin
                if (held_count >= CAP)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    byte_store[tail_slot] = r.data;
                    tail_slot = (tail_slot + 1) % CAP;
                    held_count++;
                end
            end
            CMD_POP:
            begin
                if (held_count == 0)
                begin
                    o.status = ST_EMPTY;
                end
                else
                begin
                    head_slot = (head_slot + 1) % CAP;
                    held_count--;
                end
            end
            CMD_REPLACE:
            begin
                if (held_count == 0)
                begin
                    o.status = ST_EMPTY;
                end
                else
                begin
                    byte_store[(tail_slot + CAP - 1) % CAP] = r.data;
                end
            end
            CMD_MEMBER:
            begin
                for (k = 0; k < held_count; k++)
                begin
                    if (byte_store[(head_slot + k) % CAP] == r.data)
                    begin
                        o.found = 1'b1;
                    end
                end
            end
            CMD_COUNT:
            begin
                if (held_count == 0)
                begin
                    o.status = ST_EMPTY;
                end
                else
                begin
                    for (k = 0; k < held_count; k++)
                    begin
                        if (byte_store[(head_slot + k) % CAP] == r.data)
                        begin
                            hits++;
                        end
                    end
                    o.match_count = hits[7:0];
                end
            end
            CMD_MAX:
            begin
                if (held_count == 0)
                begin
                    o.status = ST_EMPTY;
                end
                else
                begin
                    for (k = 0; k < held_count; k++)
                    begin
                        b = byte_store[(head_slot + k) % CAP];
                        if (b > o.max_value)
                        begin
                            o.max_value = b;
                        end
                    end
                end
            end
            CMD_UPPER:
            begin
                for (k = 0; k < held_count; k++)
                begin
                    b = byte_store[(head_slot + k) % CAP];
                    if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z)
                    begin
                        byte_store[(head_slot + k) % CAP] = b - ASCII_CASE_OFFSET;
                    end
                end
            end
            default:
            begin
                head_slot = 0;
                tail_slot = 0;
                held_count = 0;
            end
        endcase
        o.level = held_count[7:0];
        o.is_empty_flag = (held_count == 0);
        o.is_full_flag = (held_count >= CAP);
        o.head_value = (held_count == 0) ? 8'd0 : byte_store[head_slot];
        return o;
    endfunction

    // Offers one command word, holds it through stalls, and records the expected
    // result at the edge where it is taken.
    task automatic send_word(input cmd_t c, input logic [7:0] d, input logic typed,
                             input rsp_t want);
        req_t r;
        rsp_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        r.cmd = c;
        r.data = d;
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        predicted = command_outcome(r);
        awaited_words.push_back(typed ? want : predicted);
    endtask

    // Holds off the sender until every outstanding result word has come back.
    // At least one edge passes, so valid is never assigned twice in one step.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (awaited_words.size() != 0);
    endtask

    task automatic check_word(input rsp_t want, input rsp_t got);
        if (got.status !== want.status)
        begin
            $error("status expected %0d got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.level !== want.level)
        begin
            $error("level expected %0d got %0d", want.level, got.level);
            fail_count++;
        end
        if (got.is_empty_flag !== want.is_empty_flag)
        begin
            $error("is_empty_flag expected %0d got %0d",
                   want.is_empty_flag, got.is_empty_flag);
            fail_count++;
        end
        if (got.is_full_flag !== want.is_full_flag)
        begin
            $error("is_full_flag expected %0d got %0d",
                   want.is_full_flag, got.is_full_flag);
            fail_count++;
        end
        if (got.head_value !== want.head_value)
        begin
            $error("head_value expected %0h got %0h", want.head_value, got.head_value);
            fail_count++;
        end
        if (got.found !== want.found)
        begin
            $error("found expected %0d got %0d", want.found, got.found);
            fail_count++;
        end
        if (got.match_count !== want.match_count)
        begin
            $error("match_count expected %0d got %0d", want.match_count, got.match_count);
            fail_count++;
        end
        if (got.max_value !== want.max_value)
        begin
            $error("max_value expected %0h got %0h", want.max_value, got.max_value);
            fail_count++;
        end
    endtask

    // Result side: takes a word whenever valid meets a low stall, then draws the
    // stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_words.size() == 0)
            begin
                $error("result word arrived with none expected");
                fail_count++;
            end
            else
            begin
                check_word(awaited_words.pop_front(), rsp);
            end
        end
        rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL char_fifo_with_search");
        $finish;
    end

    initial
    begin
        int         n;
        int         k;
        int         phase;
        int         bias;
        int         roll;
        int         push_pct;
        int         pop_pct;
        cmd_t       c;
        logic [7:0] d;

        fail_count = 0;
        cycle_count = 0;
        head_slot = 0;
        tail_slot = 0;
        held_count = 0;
        tx_idle_pct = 32;
        rx_idle_pct = 56;
        bias = 2;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        rsp_stall <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DIRECTED_ROWS; n++)
        begin
            send_word(DIRECTED[n].cmd, DIRECTED[n].data, DIRECTED[n].typed, DIRECTED[n].want);
        end

        // Fill to capacity with one byte so the count answer reaches its top,
        // then push into the full queue and move the pointers across the wrap.
        while (held_count < CAP)
        begin
            send_word(CMD_PUSH, 8'hA5, 1'b0, '0);
        end
        send_word(CMD_COUNT, 8'hA5, 1'b0, '0);
        send_word(CMD_MAX, 8'h00, 1'b0, '0);
        send_word(CMD_PUSH, 8'h3C, 1'b0, '0);
        send_word(CMD_REPLACE, 8'h61, 1'b0, '0);
        send_word(CMD_UPPER, 8'h00, 1'b0, '0);
        send_word(CMD_MEMBER, 8'h41, 1'b0, '0);
        for (k = 0; k < 3; k++)
        begin
            send_word(CMD_POP, 8'h00, 1'b0, '0);
        end
        for (k = 0; k < 3; k++)
        begin
            send_word(CMD_PUSH, 8'h30 + 8'(k), 1'b0, '0);
        end
        send_word(CMD_COUNT, 8'hA5, 1'b0, '0);
        send_word(CMD_MAX, 8'h00, 1'b0, '0);
        send_word(CMD_CLEAR, 8'h00, 1'b0, '0);
        wait_for_drain();

        // Random commands in three idling phases. The push and pop mix shifts
        // every few dozen words so the level sweeps from empty to full and back.
        for (phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 56 : 0;
            rx_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 32 : 0;
            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                begin
                    bias = $urandom_range(2);
                end
                if ($urandom_range(149) == 0)
                begin
                    wait_for_drain();
                end
                push_pct = (bias == 0) ? 60 : (bias == 1) ? 15 : 30;
                pop_pct = (bias == 1) ? 50 : 20;
                roll = $urandom_range(99);
                if (roll < push_pct)
                begin
                    c = CMD_PUSH;
                end
                else if (roll < push_pct + pop_pct)
                begin
                    c = CMD_POP;
                end
                else if (roll == 99)
                begin
                    c = CMD_CLEAR;
                end
                else
                begin
                    c = cmd_t'($urandom_range(CMD_UPPER, CMD_REPLACE));
                end
                // Searches often look for a byte that is really stored, and many
                // bytes are lowercase letters so that uppercasing has work to do.
                roll = $urandom_range(9);
                if (held_count > 0 && roll < 4)
                begin
                    d = byte_store[(head_slot + $urandom_range(held_count - 1)) % CAP];
                end
                else if (roll < 7)
                begin
                    d = 8'($urandom_range(ASCII_LOWER_Z, ASCII_LOWER_A));
                end
                else
                begin
                    d = 8'($urandom_range(255));
                end
                send_word(c, d, 1'b0, '0);
            end
            wait_for_drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && awaited_words.size() == 0)
        begin
            $display("PASS char_fifo_with_search");
        end
        else
        begin
            $display("FAIL char_fifo_with_search");
        end
        $finish;
    end

endmodule
